[rtl/bbff_pkg.sv]
package bbff_pkg;

  // command codes
  localparam logic [2:0] CMD_LOAD_BYTE   = 3'd0;
  localparam logic [2:0] CMD_FORMAT      = 3'd1;
  localparam logic [2:0] CMD_WRITE_BIT   = 3'd2;
  localparam logic [2:0] CMD_WRITE_RANGE = 3'd3;
  localparam logic [2:0] CMD_READ_BIT    = 3'd4;
  localparam logic [2:0] CMD_FIND_RUN    = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_BLOCKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_BLOCKS = 2'd1;

  localparam logic [12:0] DISK_BLOCKS_RST   = 13'd4096;
  localparam logic [3:0]  BITMAP_BLOCKS_RST = 4'd1;

  // scan limit: a found run must end below this block
  localparam int unsigned START_LIMIT = 4096;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] blk_index;
    logic [12:0] run_length;
    logic        bit_value;
    logic [8:0]  byte_address;
    logic [7:0]  byte_data;
  } in_t;

  typedef struct packed {
    logic        read_bit;
    logic        found;
    logic [11:0] run_start;
  } out_t;

  typedef enum logic [1:0] {
    WSEL_LOAD,
    WSEL_FMT,
    WSEL_RMW
  } wsel_t;

  typedef struct packed {
    logic  latch;
    logic  rd;
    logic  wr;
    wsel_t wsel;
    logic  step;
    logic  scan;
    logic  bit_res;
    logic  res_load;
  } ctl_t;

  typedef struct packed {
    logic fmt_last;
    logic rmw_last;
    logic find_done;
  } sts_t;

endpackage

[rtl/bbff_ctrl.sv]
module bbff_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2:0]        in_cmd,
  input  logic              out_ready,
  input  bbff_pkg::sts_t    sts,
  output logic              in_ready,
  output logic              out_valid,
  output bbff_pkg::ctl_t    ctl
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_FMT,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_BIT_RD,
    ST_BIT_RES,
    ST_FIND,
    ST_DONE
  } state_t;

  state_t state;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    ctl = '0;
    ctl.wsel = bbff_pkg::WSEL_RMW;
    case (state)
      ST_IDLE: begin
        ctl.latch = in_valid;
      end
      ST_LOAD_WR: begin
        ctl.wr = 1'b1;
        ctl.wsel = bbff_pkg::WSEL_LOAD;
      end
      ST_FMT: begin
        ctl.wr = 1'b1;
        ctl.wsel = bbff_pkg::WSEL_FMT;
        ctl.step = 1'b1;
      end
      ST_RMW_RD: begin
        ctl.rd = 1'b1;
      end
      ST_RMW_WR: begin
        ctl.wr = 1'b1;
        ctl.step = !sts.rmw_last;
      end
      ST_BIT_RD: begin
        ctl.rd = 1'b1;
      end
      ST_BIT_RES: begin
        ctl.bit_res = 1'b1;
      end
      ST_FIND: begin
        ctl.scan = 1'b1;
      end
      ST_DONE: begin
        ctl.res_load = !out_valid || out_ready;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (ctl.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            case (in_cmd)
              bbff_pkg::CMD_LOAD_BYTE:   state <= ST_LOAD_WR;
              bbff_pkg::CMD_FORMAT:      state <= ST_FMT;
              bbff_pkg::CMD_WRITE_BIT:   state <= ST_RMW_RD;
              bbff_pkg::CMD_WRITE_RANGE: state <= ST_RMW_RD;
              bbff_pkg::CMD_READ_BIT:    state <= ST_BIT_RD;
              bbff_pkg::CMD_FIND_RUN:    state <= ST_FIND;
              default:                   state <= ST_DONE;
            endcase
          end
        end
        ST_LOAD_WR: state <= ST_DONE;
        ST_FMT: begin
          if (sts.fmt_last) state <= ST_DONE;
        end
        ST_RMW_RD: state <= ST_RMW_WR;
        ST_RMW_WR: begin
          state <= sts.rmw_last ? ST_DONE : ST_RMW_RD;
        end
        ST_BIT_RD: state <= ST_BIT_RES;
        ST_BIT_RES: state <= ST_DONE;
        ST_FIND: begin
          if (sts.find_done) state <= ST_DONE;
        end
        ST_DONE: begin
          if (ctl.res_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/bbff_dp.sv]
module bbff_dp #(
  parameter int unsigned MAP_BITS = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bbff_pkg::in_t                     in_data,
  input  logic                              cfg_write,
  input  logic [bbff_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bbff_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  bbff_pkg::ctl_t                    ctl,
  output bbff_pkg::sts_t                    sts,
  output bbff_pkg::out_t                    out_data
);

  localparam int unsigned MAP_BYTES = (MAP_BITS + 7) / 8;
  localparam int unsigned AW = $clog2(MAP_BYTES);
  localparam int unsigned PTR_SPAN = (MAP_BYTES > 1024) ? MAP_BYTES : 1024;
  localparam int unsigned PW = $clog2(PTR_SPAN + 1);
  localparam int unsigned WW = PW + 3;
  localparam int unsigned LIMIT =
      (MAP_BITS < bbff_pkg::START_LIMIT) ? MAP_BITS : bbff_pkg::START_LIMIT;
  localparam int unsigned LAST_SCAN = (LIMIT - 1) / 8;

  logic [7:0]    mem [MAP_BYTES];
  logic [7:0]    rdata;
  logic [PW-1:0] ptr;
  logic [PW-1:0] dptr;
  logic          dvld;

  logic [12:0]   disk_blocks;
  logic [3:0]    bitmap_blocks;

  // latched item, range end one bit wider so start plus length never wraps
  logic [11:0]   lo;
  logic [13:0]   hi;
  logic [12:0]   n;
  logic          val;
  logic [7:0]    byte_data;

  logic [12:0]   cnt;
  logic          rbit;
  logic          found;
  logic [11:0]   start;

  logic [7:0]    fmt_byte;
  logic [7:0]    mask;
  logic [7:0]    wdata;
  logic          in_map;
  logic          issue;
  logic [12:0]   cnt_v;
  logic          hit_v;
  logic [11:0]   start_v;
  logic [WW-1:0] nxt_base;

  assign in_map = (ptr < PW'(MAP_BYTES));
  assign issue = ctl.scan && (ptr <= PW'(LAST_SCAN));

  // byte contents produced by format, and the bit mask of a write
  always_comb begin
    logic [WW-1:0] b;
    logic [WW-1:0] reserved;
    reserved = WW'(bitmap_blocks) + WW'(1);
    fmt_byte = '0;
    mask = '0;
    for (int k = 0; k < 8; k++) begin
      b = {ptr, 3'(k)};
      fmt_byte[3'(7 - k)] = (b < WW'(MAP_BITS)) &&
                           ((b < reserved) || (b >= WW'(disk_blocks)));
      mask[3'(7 - k)] = (b >= WW'(lo)) && (b < WW'(hi)) && (b < WW'(MAP_BITS));
    end
  end

  always_comb begin
    case (ctl.wsel)
      bbff_pkg::WSEL_LOAD: wdata = byte_data;
      bbff_pkg::WSEL_FMT:  wdata = fmt_byte;
      bbff_pkg::WSEL_RMW:  wdata = (rdata & ~mask) | (val ? mask : 8'h00);
      default:             wdata = rdata;
    endcase
  end

  // run counting over one byte, MSB first
  always_comb begin
    logic [WW-1:0] b;
    cnt_v = cnt;
    hit_v = 1'b0;
    start_v = '0;
    for (int k = 0; k < 8; k++) begin
      b = {dptr, 3'(k)};
      if (!hit_v && (b < WW'(LIMIT))) begin
        if (!rdata[3'(7 - k)]) begin
          cnt_v = cnt_v + 13'd1;
        end else begin
          cnt_v = '0;
        end
        if (cnt_v == n) begin
          hit_v = 1'b1;
          start_v = 12'(b + WW'(1) - WW'(n));
        end
      end
    end
  end

  assign nxt_base = {ptr + PW'(1), 3'b000};
  assign sts.fmt_last = (ptr == PW'(MAP_BYTES - 1));
  assign sts.rmw_last = (nxt_base >= WW'(hi)) || (nxt_base >= WW'(MAP_BITS));
  assign sts.find_done = (n == '0) || (dvld && (hit_v || (dptr == PW'(LAST_SCAN))));

  always_ff @(posedge clk) begin
    if (ctl.wr && in_map) begin
      mem[ptr[AW-1:0]] <= wdata;
    end
    if (ctl.rd || issue) begin
      rdata <= mem[ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_blocks <= bbff_pkg::DISK_BLOCKS_RST;
      bitmap_blocks <= bbff_pkg::BITMAP_BLOCKS_RST;
      dvld <= 1'b0;
    end else begin
      if (cfg_write && (cfg_index == bbff_pkg::CFG_DISK_BLOCKS)) begin
        disk_blocks <= cfg_data;
      end
      if (cfg_write && (cfg_index == bbff_pkg::CFG_BITMAP_BLOCKS)) begin
        bitmap_blocks <= cfg_data[3:0];
      end
      dvld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    dptr <= ptr;
    if (ctl.latch) begin
      lo <= in_data.blk_index;
      hi <= (in_data.cmd == bbff_pkg::CMD_WRITE_BIT) ?
            14'(in_data.blk_index) + 14'd1 :
            14'(in_data.blk_index) + 14'(in_data.run_length);
      n <= in_data.run_length;
      val <= in_data.bit_value;
      byte_data <= in_data.byte_data;
      cnt <= '0;
      rbit <= 1'b0;
      found <= 1'b0;
      start <= '0;
      case (in_data.cmd)
        bbff_pkg::CMD_LOAD_BYTE:   ptr <= PW'(in_data.byte_address);
        bbff_pkg::CMD_WRITE_BIT:   ptr <= PW'(in_data.blk_index[11:3]);
        bbff_pkg::CMD_WRITE_RANGE: ptr <= PW'(in_data.blk_index[11:3]);
        bbff_pkg::CMD_READ_BIT:    ptr <= PW'(in_data.blk_index[11:3]);
        default:                   ptr <= '0;
      endcase
    end else begin
      if (ctl.step || issue) begin
        ptr <= ptr + PW'(1);
      end
      if (ctl.scan && dvld) begin
        cnt <= cnt_v;
        if (hit_v) begin
          found <= 1'b1;
          start <= start_v;
        end
      end
      if (ctl.bit_res) begin
        rbit <= (WW'(lo) < WW'(MAP_BITS)) && rdata[3'(7) - lo[2:0]];
      end
    end
    if (ctl.res_load) begin
      out_data.read_bit <= rbit;
      out_data.found <= found;
      out_data.run_start <= start;
    end
  end

endmodule

[rtl/block_bitmap_first_fit.sv]
// Free-block bitmap with first-fit run search. One bit per disk block, MSB first
// within each byte, a set bit marks a used block; the map lives in a single-port
// byte memory of MAP_BITS/8 entries (rounded up) that is undefined after reset until loaded or
// formatted (there is no clearing pass). Every transaction yields exactly one result
// transaction. Load byte writes one byte, read bit reads one byte, write bit and write
// range read and write back each byte touched, format writes the whole map (one byte
// written per cycle), find run reads at most min(MAP_BITS,4096)/8 bytes, rounded up (one
// byte read and scanned per cycle, stopping at the first fit), and unused command codes
// go straight to the result. All of these go through the one memory port. A new
// transaction is taken only when the previous one has finished, but a finished result
// may still sit in the output register waiting for out_ready.
module block_bitmap_first_fit #(
  parameter int unsigned MAP_BITS = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bbff_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bbff_pkg::out_t                    out_data,
  input  logic                              cfg_write,
  input  logic [bbff_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bbff_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // command strobes from the sequencer, status flags back from the datapath
  bbff_pkg::ctl_t ctl;
  bbff_pkg::sts_t sts;

  // sequencer: one transaction at a time, owns the handshakes
  bbff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  // datapath: bitmap memory, byte pointer, run counter, config and result registers
  bbff_dp #(
    .MAP_BITS (MAP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // an accepted transaction leaves the block busy in the cycle after the accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accept");

  // a result that did not find a run carries a zero start block
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.run_start == '0)
    else $error("run start set without a found run");

  // one command never reports both a bit read and a found run
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.read_bit && out_data.found))
    else $error("read bit and found both set");

  // a result only shows up while the sequencer is busy or holding it
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised while idle");
`endif

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAP_BITS  = 4096;
  localparam int unsigned MAP_BYTES = MAP_BITS / 8;
  localparam int unsigned IN_W      = $bits(bbff_pkg::in_t);
  // longest gap or stall either side draws per transaction
  localparam int unsigned GAP_MAX = 13;
  // settle time after the last answer, long enough to cover a full-map write range
  localparam int unsigned SETTLE_CYCLES = 1100;
  // cap on printed mismatch lines, every mismatch is still counted
  localparam int unsigned PRINT_CAP = 100;

  // command codes the block must treat as no-ops
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  // register indexes past the two real registers
  localparam logic [bbff_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [bbff_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  bbff_pkg::in_t                   in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  bbff_pkg::out_t                  out_data;
  logic                            cfg_write = 1'b0;
  logic [bbff_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bbff_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  block_bitmap_first_fit #(
    .MAP_BITS(MAP_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs on a handshake
  initial begin
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the allocator: bitmap bytes and the two registers
  // ---------------------------------------------------------------------------
  logic [7:0]  map_shadow [MAP_BYTES];
  logic [12:0] shadow_disk_blocks   = bbff_pkg::DISK_BLOCKS_RST;
  logic [3:0]  shadow_bitmap_blocks = bbff_pkg::BITMAP_BLOCKS_RST;

  // answers owed by the block, oldest first
  bbff_pkg::out_t answer_queue [$];

  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned finds_hit;
  int unsigned settings_applied;
  int unsigned cmd_seen [8];

  // sender and receiver each flip between random idling and back-to-back bursts
  bit          sender_burst;
  bit          receiver_burst;
  // sender keeps valid up across transactions when the next gap is zero
  bit          valid_held;
  int unsigned next_gap;

  // block b lives in bit 7 - b%8 of byte b/8, set means used
  function automatic logic block_used(input int unsigned b);
    if (b >= MAP_BITS) return 1'b0;
    return map_shadow[b / 8][7 - (b % 8)];
  endfunction

  function automatic void mark_block(input int unsigned b, input logic used);
    if (b < MAP_BITS) map_shadow[b / 8][7 - (b % 8)] = used;
  endfunction

  // reserved blocks (boot plus bitmap) and blocks past the disk end are used
  function automatic void format_shadow();
    int unsigned reserved;
    reserved = 1 + shadow_bitmap_blocks;
    for (int unsigned b = 0; b < MAP_BITS; b++)
      mark_block(b, (b < reserved) || (b >= shadow_disk_blocks));
  endfunction

  // lowest run of len free blocks; zero length never fits
  function automatic bbff_pkg::out_t first_fit(input int unsigned len);
    bbff_pkg::out_t res;
    int unsigned    run;
    res = '0;
    run = 0;
    if (len == 0) return res;
    for (int unsigned b = 0; b < bbff_pkg::START_LIMIT && b < MAP_BITS; b++) begin
      run = block_used(b) ? 0 : run + 1;
      if (run == len) begin
        res.found     = 1'b1;
        res.run_start = 12'(b + 1 - len);
        return res;
      end
    end
    return res;
  endfunction

  // update the shadow map for one command and return what the block must answer
  function automatic bbff_pkg::out_t apply_command(input bbff_pkg::in_t c);
    bbff_pkg::out_t res;
    int unsigned    stop;
    res = '0;
    stop = c.blk_index + c.run_length;
    case (c.cmd)
      bbff_pkg::CMD_LOAD_BYTE: begin
        if (c.byte_address < MAP_BYTES) map_shadow[c.byte_address] = c.byte_data;
      end
      bbff_pkg::CMD_FORMAT: begin
        format_shadow();
      end
      bbff_pkg::CMD_WRITE_BIT: begin
        mark_block(c.blk_index, c.bit_value);
      end
      bbff_pkg::CMD_WRITE_RANGE: begin
        // no wrap: the range is clipped at the end of the map
        for (int unsigned b = c.blk_index; b < stop && b < MAP_BITS; b++)
          mark_block(b, c.bit_value);
      end
      bbff_pkg::CMD_READ_BIT: begin
        res.read_bit = block_used(c.blk_index);
      end
      bbff_pkg::CMD_FIND_RUN: begin
        res = first_fit(c.run_length);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic bbff_pkg::in_t make_cmd(input logic [2:0] op, input int unsigned idx,
                                             input int unsigned len, input logic used,
                                             input int unsigned addr,
                                             input int unsigned bits);
    bbff_pkg::in_t c;
    c = '0;
    c.cmd          = op;
    c.blk_index    = 12'(idx);
    c.run_length   = 13'(len);
    c.bit_value    = used;
    c.byte_address = 9'(addr);
    c.byte_data    = 8'(bits);
    return c;
  endfunction

  function automatic int unsigned draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // command side: one transaction per call, valid held steady until accepted
  // ---------------------------------------------------------------------------
  task automatic send_command(input bbff_pkg::in_t c);
    if (!valid_held) repeat (next_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_ready !== 1'b1);
    // accepted at this edge, so the shadow moves now
    answer_queue.push_back(apply_command(c));
    cmd_seen[c.cmd]++;
    if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
    next_gap   = draw_wait(sender_burst);
    valid_held = (next_gap == 0);
    if (!valid_held) in_valid <= 1'b0;
  endtask

  // drop a valid left up for a back-to-back follow-on that is not coming
  task automatic stop_sending();
    if (valid_held) in_valid <= 1'b0;
    valid_held = 1'b0;
    next_gap   = 0;
  endtask

  // every command answers once, so an empty queue means the block is idle
  task automatic wait_idle();
    stop_sending();
    while (answer_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // back-to-back register writes with the enable held, optionally poking the
  // unused indexes, which must change nothing
  task automatic set_registers(input logic [12:0] total, input logic [12:0] bb_word,
                               input bit poke_unused);
    cfg_write <= 1'b1;
    cfg_index <= bbff_pkg::CFG_DISK_BLOCKS;
    cfg_data  <= total;
    @(posedge clk);
    shadow_disk_blocks = total;
    cfg_index <= bbff_pkg::CFG_BITMAP_BLOCKS;
    cfg_data  <= bb_word;
    @(posedge clk);
    shadow_bitmap_blocks = bb_word[3:0];
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED_LO;
      cfg_data  <= '1;
      @(posedge clk);
      cfg_index <= CFG_UNUSED_HI;
      cfg_data  <= '0;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls on out_ready, each transaction checked in order
  // ---------------------------------------------------------------------------
  task automatic check_result(input bbff_pkg::out_t got);
    bbff_pkg::out_t want;
    results_checked++;
    if (answer_queue.size() == 0) begin
      report_mismatch($sformatf("unexpected result rd=%0b found=%0b start=%0d",
                                got.read_bit, got.found, got.run_start));
      return;
    end
    want = answer_queue.pop_front();
    if (got.read_bit !== want.read_bit)
      report_mismatch($sformatf("result %0d read_bit %b, want %b",
                                results_checked, got.read_bit, want.read_bit));
    if (got.found !== want.found)
      report_mismatch($sformatf("result %0d found %b, want %b",
                                results_checked, got.found, want.found));
    if (got.run_start !== want.run_start)
      report_mismatch($sformatf("result %0d run_start %0d, want %0d",
                                results_checked, got.run_start, want.run_start));
    if (want.found) finds_hit++;
  endtask

  initial begin : result_checker
    int unsigned stall;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
      stall = draw_wait(receiver_burst);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_result(out_data);
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // writes only, since the store is undefined until written; ends with a format
  task automatic test_before_format();
    send_command(make_cmd(bbff_pkg::CMD_LOAD_BYTE, 0, 0, 1'b0, 0, 8'hA5));
    send_command(make_cmd(bbff_pkg::CMD_LOAD_BYTE, 0, 0, 1'b0, MAP_BYTES - 1, 8'h5A));
    send_command(make_cmd(bbff_pkg::CMD_WRITE_BIT, 0, 0, 1'b1, 0, 0));
    send_command(make_cmd(bbff_pkg::CMD_WRITE_BIT, MAP_BITS - 1, 0, 1'b0, 0, 0));
    // range runs off the end of the map and must be clipped there
    send_command(make_cmd(bbff_pkg::CMD_WRITE_RANGE, MAP_BITS - 6, 8191, 1'b1, 0, 0));
    send_command(make_cmd(bbff_pkg::CMD_WRITE_RANGE, 100, 0, 1'b1, 0, 0));
    send_command(make_cmd(CMD_SPARE_6, 7, 7, 1'b1, 7, 8'hFF));
    send_command(make_cmd(CMD_SPARE_7, 4095, 8191, 1'b1, 511, 8'hFF));
    send_command(make_cmd(bbff_pkg::CMD_FORMAT, 0, 0, 1'b0, 0, 0));
  endtask

  // reset registers: blocks 0 and 1 reserved, the rest free
  task automatic test_directed_after_format();
    send_command(make_cmd(bbff_pkg::CMD_READ_BIT, 0, 0, 1'b0, 0, 0));
    send_command(make_cmd(bbff_pkg::CMD_READ_BIT, 2, 0, 1'b0, 0, 0));
    send_command(make_cmd(bbff_pkg::CMD_READ_BIT, MAP_BITS - 1, 0, 1'b0, 0, 0));
    // zero length never fits
    send_command(make_cmd(bbff_pkg::CMD_FIND_RUN, 0, 0, 1'b0, 0, 0));
    send_command(make_cmd(bbff_pkg::CMD_FIND_RUN, 0, 1, 1'b0, 0, 0));
    // exactly the free tail, then one more than exists, then the widest field
    send_command(make_cmd(bbff_pkg::CMD_FIND_RUN, 0, MAP_BITS - 2, 1'b0, 0, 0));
    send_command(make_cmd(bbff_pkg::CMD_FIND_RUN, 0, MAP_BITS - 1, 1'b0, 0, 0));
    send_command(make_cmd(bbff_pkg::CMD_FIND_RUN, 0, 8191, 1'b0, 0, 0));
    // free the first byte so a run starts at block zero
    send_command(make_cmd(bbff_pkg::CMD_LOAD_BYTE, 0, 0, 1'b0, 0, 8'h00));
    send_command(make_cmd(bbff_pkg::CMD_FIND_RUN, 0, 3, 1'b0, 0, 0));
    // writing zero has to clear, not just leave the bit alone
    send_command(make_cmd(bbff_pkg::CMD_WRITE_RANGE, 0, 8, 1'b1, 0, 0));
    send_command(make_cmd(bbff_pkg::CMD_WRITE_BIT, 5, 0, 1'b0, 0, 0));
    send_command(make_cmd(bbff_pkg::CMD_READ_BIT, 5, 0, 1'b0, 0, 0));
    send_command(make_cmd(bbff_pkg::CMD_LOAD_BYTE, 0, 0, 1'b0, MAP_BYTES - 1, 8'hFF));
    send_command(make_cmd(bbff_pkg::CMD_READ_BIT, MAP_BITS - 1, 0, 1'b0, 0, 0));
    send_command(make_cmd(bbff_pkg::CMD_WRITE_RANGE, MAP_BITS - 2, 2, 1'b0, 0, 0));
    send_command(make_cmd(bbff_pkg::CMD_READ_BIT, MAP_BITS - 2, 0, 1'b0, 0, 0));
  endtask

  // format under extreme settings and probe the reserved and disk-end boundaries
  task automatic test_register_settings();
    logic [12:0] totals [6] = '{13'd0, 13'd4096, 13'd1, 13'd8191, 13'd37,
                               bbff_pkg::DISK_BLOCKS_RST};
    logic [3:0]  bbs    [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, bbff_pkg::BITMAP_BLOCKS_RST};
    int unsigned probe  [4];
    int unsigned reserved;
    for (int s = 0; s < 6; s++) begin
      wait_idle();
      set_registers(totals[s], 13'(bbs[s]), s == 2);
      send_command(make_cmd(bbff_pkg::CMD_FORMAT, 0, 0, 1'b0, 0, 0));
      reserved = 1 + bbs[s];
      probe[0] = reserved - 1;
      probe[1] = reserved;
      probe[2] = totals[s] - 1;
      probe[3] = totals[s];
      for (int k = 0; k < 4; k++)
        send_command(make_cmd(bbff_pkg::CMD_READ_BIT, probe[k], 0, 1'b0, 0, 0));
      for (int k = 0; k < 8; k++) begin
        if (k % 2 == 0)
          send_command(make_cmd(bbff_pkg::CMD_FIND_RUN, 0, $urandom_range(1, 64),
                                1'b0, 0, 0));
        else
          send_command(make_cmd(bbff_pkg::CMD_READ_BIT, $urandom_range(0, MAP_BITS - 1),
                                0, 1'b0, 0, 0));
      end
    end
  endtask

  // mostly cheap commands and short finds, a few full-map ranges and formats;
  // fields the command ignores carry random noise
  function automatic bbff_pkg::in_t random_command();
    bbff_pkg::in_t c;
    int unsigned   pick;
    c = IN_W'({$urandom(), $urandom()});
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      c.cmd = bbff_pkg::CMD_LOAD_BYTE;
      // solid bytes give long free runs and walls, random ones give texture
      case ($urandom_range(0, 2))
        0: c.byte_data = 8'h00;
        1: c.byte_data = 8'hFF;
        default: begin
        end
      endcase
    end else if (pick < 14) begin
      c.cmd = bbff_pkg::CMD_FORMAT;
    end else if (pick < 32) begin
      c.cmd = bbff_pkg::CMD_WRITE_BIT;
    end else if (pick < 46) begin
      c.cmd        = bbff_pkg::CMD_WRITE_RANGE;
      c.run_length = ($urandom_range(0, 9) == 0) ? 13'($urandom()) :
                                                   13'($urandom_range(0, 40));
      // lean toward freeing so finds have runs to hit
      c.bit_value  = ($urandom_range(0, 4) < 3) ? 1'b0 : 1'b1;
    end else if (pick < 64) begin
      c.cmd = bbff_pkg::CMD_READ_BIT;
    end else if (pick < 94) begin
      c.cmd = bbff_pkg::CMD_FIND_RUN;
      pick  = $urandom_range(0, 9);
      if (pick < 7)      c.run_length = 13'($urandom_range(1, 24));
      else if (pick < 9) c.run_length = 13'($urandom_range(0, 300));
      else               c.run_length = 13'($urandom());
    end else begin
      c.cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
    end
    return c;
  endfunction

  // phases of random commands with new register settings in between
  task automatic test_random_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned phase_len;
    logic [12:0] total;
    logic [3:0]  bb;
    sent = 0;
    while (sent < count) begin
      phase_len = $urandom_range(90, 170);
      for (int unsigned k = 0; k < phase_len && sent < count; k++) begin
        send_command(random_command());
        sent++;
      end
      if (sent < count) begin
        wait_idle();
        case ($urandom_range(0, 5))
          0: total = 13'd0;
          1: total = 13'd4096;
          default: total = 13'($urandom_range(0, 4096));
        endcase
        bb = 4'($urandom_range(1, 8));
        // upper data bits are junk for the narrow register
        set_registers(total, {9'($urandom()), bb}, $urandom_range(0, 7) == 0);
        if ($urandom_range(0, 1)) begin
          send_command(make_cmd(bbff_pkg::CMD_FORMAT, 0, 0, 1'b0, 0, 0));
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_before_format();
    test_directed_after_format();
    test_register_settings();
    test_random_traffic(1060);
    stop_sending();
    while (answer_queue.size() != 0) @(posedge clk);
    // anything arriving now is a stray result
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("summary: %0d results; load %0d, format %0d, write bit %0d, write range %0d,",
             results_checked, cmd_seen[bbff_pkg::CMD_LOAD_BYTE],
             cmd_seen[bbff_pkg::CMD_FORMAT], cmd_seen[bbff_pkg::CMD_WRITE_BIT],
             cmd_seen[bbff_pkg::CMD_WRITE_RANGE]);
    $display("summary: read bit %0d, find %0d (%0d fits), spare %0d, %0d settings, %0d mismatches",
             cmd_seen[bbff_pkg::CMD_READ_BIT], cmd_seen[bbff_pkg::CMD_FIND_RUN], finds_hit,
             cmd_seen[CMD_SPARE_6] + cmd_seen[CMD_SPARE_7], settings_applied, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
